// ===== hdl/lphs_pkg.sv =====
// Shared constants, types and hash arithmetic for the linear-probing string hash set.
package lphs_pkg;

  // Table geometry and hash constants.
  localparam int TABLE_SIZE = 1021;
  localparam int HASH_BASE  = 31;
  localparam int MAX_LEN    = 8;

  // Fixed field widths of the stream words.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int STAT_W   = 2;
  localparam int OUT_IDX_W = 10;
  localparam int COLL_W   = 32;
  localparam int CHAR_W   = 5;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  // Derived widths.
  localparam int SLOT_W = $clog2(TABLE_SIZE);
  localparam int N_W    = $clog2(TABLE_SIZE + 1);

  // One Horner step is h * BASE_MOD + value, reduced by restoring division.
  localparam int    BASE_MOD = HASH_BASE % TABLE_SIZE;
  localparam longint X_MAX   = longint'(BASE_MOD) * longint'(TABLE_SIZE - 1) + 26;
  localparam int    X_W      = $clog2(X_MAX + 1);
  localparam int    QBITS    = (X_MAX / TABLE_SIZE) > 0 ? $clog2(X_MAX / TABLE_SIZE + 1) : 1;
  localparam int    D_W      = X_W + QBITS + 1;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2,
    RES_UNUSED    = 2'd3
  } res_t;

  // Slot state codes.
  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_OCCUPIED = 2'd1,
    SLOT_DELETED  = 2'd2,
    SLOT_UNUSED   = 2'd3
  } slot_st_t;

  // One table entry as it is kept in the slot memory.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    slot_st_t         st;
  } slot_t;

  localparam int SLOT_ENTRY_W = $bits(slot_t);

  // Letters map case-insensitively to 1..26, digits to 1..10, all else to 1.
  function automatic logic [CHAR_W-1:0] char_value(logic [7:0] c);
    logic [CHAR_W-1:0] v;
    v = CHAR_W'(1);
    if (c >= 8'h61 && c <= 8'h7a) begin
      v = CHAR_W'(c - 8'h60);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      v = CHAR_W'(c - 8'h40);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = CHAR_W'(c - 8'h2f);
    end
    return v;
  endfunction

  // One Horner step: (h * base + value(c)) mod TABLE_SIZE.
  function automatic logic [SLOT_W-1:0] hash_step(logic [SLOT_W-1:0] h, logic [7:0] c);
    logic [D_W-1:0] x;
    logic [D_W-1:0] d;
    x = D_W'(h) * D_W'(BASE_MOD) + D_W'(char_value(c));
    for (int k = QBITS - 1; k >= 0; k--) begin
      d = D_W'(TABLE_SIZE) << k;
      if (x >= d) begin
        x = x - d;
      end
    end
    return x[SLOT_W-1:0];
  endfunction

  // Slot number as it appears in the result word.
  function automatic logic [OUT_IDX_W-1:0] out_index(logic [SLOT_W-1:0] s);
    logic [OUT_IDX_W+SLOT_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, s};
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/lphs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/linear_probe_string_hash_set_core.sv =====
// Hash set of short strings with open addressing and linear probing: top level.
//
// Each input word carries an insert, search or remove command and a key of up to eight
// characters. After reset the block clears every slot of the slot memory and holds
// in_tready low meanwhile. A command then hashes its key, one character a cycle, and
// probes slots one after another: each probe is one read of the slot memory, whose
// registered read port puts the S_READ state before the slot is judged in S_CHECK. A
// finished result waits in an output register, so the next command is accepted while
// it is unread.
module linear_probe_string_hash_set_core
  import lphs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Fields from bit 0: cmd[1:0], key_chars[65:2], key_length[69:66], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: status_code[1:0], slot_index[11:2], collision_total[43:12], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] probe_r, probe_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  res_t              res_st_r, res_st_nxt;
  logic [SLOT_W-1:0] res_idx_r, res_idx_nxt;
  logic [COLL_W-1:0] coll_r, coll_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Memory port signals.
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  slot_t             mem_rdata;

  // Input word fields.
  logic [CMD_W-1:0] in_cmd;
  logic [KEY_W-1:0] in_key;
  logic [LEN_W-1:0] in_len;
  logic [LEN_W-1:0] in_len_eff;
  logic [KEY_W-1:0] in_key_eff;

  // Probe helpers.
  logic [SLOT_W-1:0] probe_next_slot;
  logic [N_W-1:0]    n_inc;
  logic              key_match;
  logic [2:0]        char_sel;
  logic [LEN_W-1:0]  cnt_dec;
  logic              out_free;

  assign in_cmd = in_tdata[CMD_W-1:0];
  assign in_key = in_tdata[CMD_W+KEY_W-1:CMD_W];
  assign in_len = in_tdata[CMD_W+KEY_W+LEN_W-1:CMD_W+KEY_W];

  // Clamp the length and zero the bytes past it.
  always_comb begin
    in_len_eff = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;
    for (int i = 0; i < KEY_W / 8; i++) begin
      in_key_eff[8*i +: 8] = (LEN_W'(i) < in_len_eff) ? in_key[8*i +: 8] : 8'h00;
    end
  end

  assign probe_next_slot = (probe_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : probe_r + SLOT_W'(1);
  assign n_inc           = n_r + N_W'(1);
  assign key_match       = (mem_rdata.key == key_r) && (mem_rdata.len == len_r);
  assign cnt_dec         = cnt_r - LEN_W'(1);
  assign char_sel        = cnt_dec[2:0];
  assign out_free        = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Slot memory: status, key and length of every slot.
  lphs_ram #(
    .WIDTH(SLOT_ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_slot_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(probe_r),
    .rdata(mem_rdata)
  );

  // Sequencer: clear, hash one character a cycle, then read and judge one slot per probe.
  // Outside the clearing pass, a slot is only written at the end of a command, so no read of it can be in flight.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    probe_nxt   = probe_r;
    n_nxt       = n_r;
    res_st_nxt  = res_st_r;
    res_idx_nxt = res_idx_r;
    coll_nxt    = coll_r;
    mem_we      = 1'b0;
    mem_waddr   = probe_r;
    mem_wdata   = '{len: len_r, key: key_r, st: SLOT_OCCUPIED};

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '{len: '0, key: '0, st: SLOT_EMPTY};
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          key_nxt   = in_key_eff;
          len_nxt   = in_len_eff;
          cnt_nxt   = in_len_eff;
          probe_nxt = '0;
          n_nxt     = '0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        // Horner form, last character first.
        if (cnt_r != '0) begin
          probe_nxt = hash_step(probe_r, key_r[8*char_sel +: 8]);
          cnt_nxt   = cnt_dec;
        end else if (cmd_r == CMD_UNUSED) begin
          res_st_nxt  = RES_NOT_FOUND;
          res_idx_nxt = '0;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_INSERT) begin
          if (mem_rdata.st != SLOT_OCCUPIED) begin
            mem_we      = 1'b1;
            res_st_nxt  = RES_OK;
            res_idx_nxt = probe_r;
            if (n_r != '0 && coll_r != '1) begin
              coll_nxt = coll_r + COLL_W'(1);
            end
            state_nxt = S_RESP;
          end else if (n_inc == N_W'(TABLE_SIZE)) begin
            res_st_nxt  = RES_FULL;
            res_idx_nxt = '0;
            if (coll_r != '1) begin
              coll_nxt = coll_r + COLL_W'(1);
            end
            state_nxt = S_RESP;
          end else begin
            probe_nxt = probe_next_slot;
            n_nxt     = n_inc;
            state_nxt = S_READ;
          end
        end else begin
          // Search and remove share the lookup.
          if (mem_rdata.st == SLOT_EMPTY) begin
            res_st_nxt  = RES_NOT_FOUND;
            res_idx_nxt = '0;
            state_nxt   = S_RESP;
          end else if (mem_rdata.st == SLOT_OCCUPIED && key_match) begin
            if (cmd_r == CMD_REMOVE) begin
              mem_we    = 1'b1;
              mem_wdata = '{len: mem_rdata.len, key: mem_rdata.key, st: SLOT_DELETED};
            end
            res_st_nxt  = RES_OK;
            res_idx_nxt = probe_r;
            state_nxt   = S_RESP;
          end else if (n_inc == N_W'(TABLE_SIZE)) begin
            res_st_nxt  = RES_NOT_FOUND;
            res_idx_nxt = '0;
            state_nxt   = S_RESP;
          end else begin
            probe_nxt = probe_next_slot;
            n_nxt     = n_inc;
            state_nxt = S_READ;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the result once the previous word has gone.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (state_r == S_RESP && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{(OUT_DATA_W - STAT_W - OUT_IDX_W - COLL_W){1'b0}},
                        coll_r, out_index(res_idx_r), res_st_r};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      coll_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      coll_r       <= coll_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Command payload and probe state.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    len_r       <= len_nxt;
    cnt_r       <= cnt_nxt;
    probe_r     <= probe_nxt;
    n_r         <= n_nxt;
    res_st_r    <= res_st_nxt;
    res_idx_r   <= res_idx_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== hdl/lphs_checker.sv =====
// Port-level checks for the hash set core, bound to its top level.
module lphs_checker
  import lphs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The clearing pass follows every reset, so no word is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during the clearing pass");

  // A failed command reports slot zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != RES_OK |-> out_tdata[11:2] == '0)
    else $error("nonzero slot on a failed command");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != RES_UNUSED)
    else $error("undefined status code");

  // Zero fill above the collision count.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:44] == '0)
    else $error("fill bits set in result word");

endmodule

bind linear_probe_string_hash_set_core lphs_checker u_lphs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tdata (out_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
